@@ hw/rtl/diff_drive_odometry_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the odometry unit
// Implication checks clocked on aclk and held off while in reset.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_UNIT_ASSERT_SVH

// Same-cycle implication
`define DDO_ASSERT_SAME(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("odometry check failed");

// Next-cycle implication
`define DDO_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("odometry check failed");

`endif

@@ hw/rtl/ddo_pkg.sv @@
// ----------------------------------------------------------------------------
// Odometry package
// Sequencer states, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddo_pkg;

    localparam int unsigned CW = 34;              // CORDIC datapath width
    localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032875;

    localparam logic REG_METRES_PER_TICK = 1'b0;
    localparam logic REG_TURN_PER_TICK   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_MUL_D,
        ST_TRIG,
        ST_TRIG_WAIT,
        ST_MUL_X,
        ST_MUL_Y,
        ST_UPDATE
    } seq_state_t;

    // Arctangent of 2^-k in 2^-32 turn units
    function automatic logic [31:0] atan_at(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;  5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;  5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;  5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;  5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;  5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;  5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/ddo_cordic.sv @@
// ----------------------------------------------------------------------------
// Iterative CORDIC
// Rotation-mode sine and cosine, one micro-rotation per cycle, Q1.30 out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_cordic #(
    parameter int unsigned ITER = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [31:0]                    angle,
    output logic                           done,
    output logic signed [ddo_pkg::CW-1:0]  cos_out,
    output logic signed [ddo_pkg::CW-1:0]  sin_out
);
    import ddo_pkg::*;

    localparam int unsigned NW = $clog2(ITER + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 flip_reg;
    logic [NW-1:0]        cnt_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;

    logic [31:0]          folded;
    logic                 flip;
    logic [4:0]           k;
    logic signed [CW-1:0] dx, dy, at;

    // Fold the angle into the right half-plane
    always_comb begin
        flip   = angle[31] ^ angle[30];
        folded = flip ? (angle - 32'h80000000) : angle;
        k      = cnt_reg[4:0];
        dx     = y_reg >>> k;
        dy     = x_reg >>> k;
        at     = $signed({{(CW-32){1'b0}}, atan_at(k)});
    end

    // Step the rotation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == NW'(ITER - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            flip_reg <= flip;
            x_reg    <= CORDIC_START;
            y_reg    <= '0;
            z_reg    <= $signed({{(CW-32){folded[31]}}, folded});
        end else if (busy_reg) begin
            if (!z_reg[CW-1]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule

@@ hw/rtl/diff_drive_odometry_unit.sv @@
// ----------------------------------------------------------------------------
// Differential-drive odometry unit
// Integrates wheel ticks into travel, heading and midpoint-heading position.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  s_axis  | in        | tdata: left_step[15:0], right_step[31:16]
//  m_axis  | out       | tdata: x, y, heading, centre, left, right, totals
//  apb     | in/out    | reg 0 metres_per_tick @0x0, reg 1 turn_per_tick @0x4
//
//  After a beat is accepted the sequencer forms the left, right and difference
//  products, runs the CORDIC loop, forms the x and y products and commits; a new
//  beat is taken only once it is back in idle, paced by the single shared 34x34
//  multiplier (five products) and the CORDIC loop. s_tready is high only while the sequencer is idle.
//  A finished result waits in the output register; the next beat is accepted
//  meanwhile, and its update stalls only if the old result is still untaken.
//  Synchronous active-low reset clears all sums and both registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diff_drive_odometry_unit #(
    parameter int unsigned TRIG_ITERATIONS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // left_step[15:0], right_step[31:16]
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[47:0], pos_y[95:48], heading_angle[127:96], centre_travel[175:128],
    // left_travel[223:176], right_travel[271:224], left_total[303:272],
    // right_total[335:304]
    output logic [335:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ddo_pkg::*;

    seq_state_t state_reg, state_next;

    logic [31:0] mpt_reg, tpt_reg;
    logic signed [15:0] left_reg, right_reg;

    logic [31:0] ltot_reg, rtot_reg, head_reg, dh_reg;
    logic [47:0] ldist_reg, rdist_reg, cdist_reg, x_reg, y_reg;

    logic signed [47:0] pl_reg, pr_reg;
    logic signed [32:0] cstep_reg;
    logic [47:0]        xstep_reg;

    logic signed [CW-1:0]   mul_a, mul_b;
    logic signed [2*CW-1:0] prod_reg;

    logic               out_valid_reg;
    logic [335:0]       out_data_reg;

    logic               trig_start, trig_done;
    logic [31:0]        mid_angle;
    logic signed [CW-1:0] cos_v, sin_v;

    logic               wr_en, slot_free, do_update;
    logic signed [16:0] diff;
    logic signed [48:0] dsum16, dsum17;
    logic signed [49:0] csum;
    logic signed [48:0] lsum, rsum;
    logic signed [2*CW-1:0] ysum;
    logic [32:0]        lstep, rstep;

    // Register port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    always_comb begin
        unique case (paddr[2])
            REG_METRES_PER_TICK: prdata = mpt_reg;
            REG_TURN_PER_TICK:   prdata = tpt_reg;
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpt_reg <= '0;
            tpt_reg <= '0;
        end else if (wr_en) begin
            if (paddr[2] == REG_METRES_PER_TICK) mpt_reg <= pwdata;
            else                                 tpt_reg <= pwdata;
        end
    end

    // Rounding of the raw products
    always_comb begin
        diff      = 17'(right_reg) - 17'(left_reg);
        dsum16    = prod_reg[48:0] + 49'sd32768;
        dsum17    = prod_reg[48:0] + 49'sd65536;
        mid_angle = head_reg + dsum17[48:17];
        csum      = 50'(pl_reg) + 50'(pr_reg) + 50'sd65536;
        lsum      = 49'(pl_reg) + 49'sd32768;
        rsum      = 49'(pr_reg) + 49'sd32768;
        lstep     = lsum[48:16];
        rstep     = rsum[48:16];
        ysum      = prod_reg + 68'sd536870912;
        slot_free = !out_valid_reg || m_tready;
        do_update = (state_reg == ST_UPDATE) && slot_free;
        trig_start = (state_reg == ST_TRIG);
    end

    // Select the shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_L: begin mul_a = CW'(left_reg);  mul_b = $signed({2'b0, mpt_reg}); end
            ST_MUL_R: begin mul_a = CW'(right_reg); mul_b = $signed({2'b0, mpt_reg}); end
            ST_MUL_D: begin mul_a = CW'(diff);      mul_b = $signed({2'b0, tpt_reg}); end
            ST_MUL_X: begin mul_a = CW'(cstep_reg); mul_b = cos_v; end
            ST_MUL_Y: begin mul_a = CW'(cstep_reg); mul_b = sin_v; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        s_tready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_MUL_L;
            ST_MUL_L:     state_next = ST_MUL_R;
            ST_MUL_R:     state_next = ST_MUL_D;
            ST_MUL_D:     state_next = ST_TRIG;
            ST_TRIG:      state_next = ST_TRIG_WAIT;
            ST_TRIG_WAIT: if (trig_done) state_next = ST_MUL_X;
            ST_MUL_X:     state_next = ST_MUL_Y;
            ST_MUL_Y:     state_next = ST_UPDATE;
            ST_UPDATE:    if (slot_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Datapath working registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            left_reg  <= s_tdata[15:0];
            right_reg <= s_tdata[31:16];
        end
        if (state_reg == ST_MUL_L || state_reg == ST_MUL_R || state_reg == ST_MUL_D ||
            state_reg == ST_MUL_X || state_reg == ST_MUL_Y) begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == ST_MUL_R) pl_reg <= prod_reg[47:0];
        if (state_reg == ST_MUL_D) pr_reg <= prod_reg[47:0];
        if (state_reg == ST_TRIG) begin
            dh_reg    <= dsum16[47:16];
            cstep_reg <= csum[49:17];
        end
        if (state_reg == ST_MUL_Y) xstep_reg <= 48'($signed(ysum[2*CW-1:30]));
    end

    // Commit the sums and load the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ltot_reg      <= '0;
            rtot_reg      <= '0;
            head_reg      <= '0;
            ldist_reg     <= '0;
            rdist_reg     <= '0;
            cdist_reg     <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tready) out_valid_reg <= 1'b0;
            if (do_update) begin
                ltot_reg      <= ltot_reg + 32'(left_reg);
                rtot_reg      <= rtot_reg + 32'(right_reg);
                head_reg      <= head_reg + dh_reg;
                ldist_reg     <= ldist_reg + 48'($signed(lstep));
                rdist_reg     <= rdist_reg + 48'($signed(rstep));
                cdist_reg     <= cdist_reg + 48'(cstep_reg);
                x_reg         <= x_reg + xstep_reg;
                y_reg         <= y_reg + 48'($signed(ysum[2*CW-1:30]));
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_update) begin
            out_data_reg <= {rtot_reg + 32'(right_reg),
                             ltot_reg + 32'(left_reg),
                             rdist_reg + 48'($signed(rstep)),
                             ldist_reg + 48'($signed(lstep)),
                             cdist_reg + 48'(cstep_reg),
                             head_reg + dh_reg,
                             y_reg + 48'($signed(ysum[2*CW-1:30])),
                             x_reg + xstep_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    ddo_cordic #(
        .ITER(TRIG_ITERATIONS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (trig_start),
        .angle   (mid_angle),
        .done    (trig_done),
        .cos_out (cos_v),
        .sin_out (sin_v)
    );

    // Checks
`include "diff_drive_odometry_unit_assert.svh"
    `DDO_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `DDO_ASSERT_SAME(a_trig_done_waiting, trig_done, state_reg == ST_TRIG_WAIT)
    `DDO_ASSERT_NEXT(a_update_shows_result, do_update, m_tvalid)

endmodule

@@ test/ddo_odometry_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry result checker
// Watches the register port and both streams, integrates the expected pose
// for every accepted beat and compares each result beat field by field.
// ----------------------------------------------------------------------------

module ddo_odometry_checker #(
    parameter int unsigned TRIG_ITERATIONS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [335:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pending_count
);
    import ddo_pkg::*;

    localparam logic [2:0] ADDR_MPT = 3'd0;
    localparam logic [2:0] ADDR_TPT = 3'd4;
    localparam logic signed [63:0] UNIT_START = 64'sd652032875;

    logic [31:0]  scale_mpt;
    logic [31:0]  gain_tpt;
    logic [31:0]  lticks, rticks, head;
    logic [47:0]  ldist, rdist, cdist, xpos, ypos;
    logic [335:0] pose_queue[$];

    assign pending_count = pose_queue.size();

    // Arithmetic shift with half-up rounding
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Iterative rotation of a binary angle into cos and sin, Q1.30
    task automatic midpoint_sincos(input logic [31:0] ang,
                                   output logic signed [63:0] c,
                                   output logic signed [63:0] s);
        logic flip;
        logic signed [63:0] x, y, z, dx, dy;
        flip = 1'b0;
        x = UNIT_START;
        y = 0;
        if (((ang + 32'h40000000) & 32'h80000000) != 0) begin
            ang = ang - 32'h80000000;
            flip = 1'b1;
        end
        z = 64'(signed'(ang));
        for (int i = 0; i < TRIG_ITERATIONS; i++) begin
            dx = y >>> (i % 32);
            dy = x >>> (i % 32);
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - 64'(atan_at(5'(i)));
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + 64'(atan_at(5'(i)));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Advance the pose by one beat of tick deltas
    task automatic integrate_pose(input logic [31:0] beat);
        logic signed [63:0] l, r, pl, pr, d, cstep, c, s;
        logic [31:0] mid;
        l = 64'(signed'(beat[15:0]));
        r = 64'(signed'(beat[31:16]));
        pl = l * $signed({32'd0, scale_mpt});
        pr = r * $signed({32'd0, scale_mpt});
        d = (r - l) * $signed({32'd0, gain_tpt});
        cstep = rnd_shift(pl + pr, 17);
        mid = head + 32'(rnd_shift(d, 17));
        midpoint_sincos(mid, c, s);
        lticks += 32'(l);
        rticks += 32'(r);
        ldist += 48'(rnd_shift(pl, 16));
        rdist += 48'(rnd_shift(pr, 16));
        cdist += 48'(cstep);
        xpos += 48'(rnd_shift(cstep * c, 30));
        ypos += 48'(rnd_shift(cstep * s, 30));
        head += 32'(rnd_shift(d, 16));
        pose_queue.push_back({rticks, lticks, rdist, ldist, cdist, head, ypos, xpos});
    endtask

    // Compare one named field and report a mismatch
    task automatic check_field(input string nm, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        logic [335:0] want;
        if (!aresetn) begin
            scale_mpt = 0; gain_tpt = 0; lticks = 0; rticks = 0; head = 0;
            ldist = 0; rdist = 0; cdist = 0; xpos = 0; ypos = 0;
            fail_count = 0;
            pose_queue.delete();
        end else begin
            // Register writes land before the next beat uses them
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_MPT) scale_mpt = pwdata;
                else if (paddr == ADDR_TPT) gain_tpt = pwdata;
            end
            if (s_tvalid && s_tready)
                integrate_pose(s_tdata);
            // Check the result beat against the oldest pose
            if (m_tvalid && m_tready) begin
                if (pose_queue.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = pose_queue.pop_front();
                    check_field("pos_x", want[47:0], m_tdata[47:0]);
                    check_field("pos_y", want[95:48], m_tdata[95:48]);
                    check_field("heading", want[127:96], m_tdata[127:96]);
                    check_field("centre", want[175:128], m_tdata[175:128]);
                    check_field("left_travel", want[223:176], m_tdata[223:176]);
                    check_field("right_travel", want[271:224], m_tdata[271:224]);
                    check_field("left_total", want[303:272], m_tdata[303:272]);
                    check_field("right_total", want[335:304], m_tdata[335:304]);
                end
            end
        end
    end

endmodule

@@ test/tb_diff_drive_odometry_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry unit testbench
// Drives tick-delta beats and register writes under random back-pressure,
// and leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------

module tb_diff_drive_odometry_unit;

    localparam int CYCLE_LIMIT = 600000;
    localparam logic [2:0] ADDR_MPT = 3'd0;
    localparam logic [2:0] ADDR_TPT = 3'd4;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [335:0] m_tdata;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count, pending_count;
    int           cycles = 0;
    int           send_idle = 0, recv_idle = 0;

    always #10 aclk = ~aclk;

    diff_drive_odometry_unit i_dut (.*);

    ddo_odometry_checker u_checker (.*);

    // Receiver stall at random, falling edge
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    // Give up well past the slowest correct run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Offer one beat and hold it until taken; drain drops valid, the next call only while it idles
    task automatic send_ticks(input logic [15:0] l, input logic [15:0] r);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r, l};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Wait until every result is in, then let the sequencer settle
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_step(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(400)) - 200);
            default: return 16'($urandom_range(20));
        endcase
    endfunction

    task automatic random_phase(input int n, input logic [31:0] mpt, input logic [31:0] tpt);
        int mode;
        drain();
        write_reg(ADDR_MPT, mpt);
        write_reg(ADDR_TPT, tpt);
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(3);
            send_ticks(rand_step(mode), rand_step(mode));
        end
    endtask

    initial begin
        logic [15:0] edge_vals[5];
        edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: zero registers, then extremes of ticks and scales
        send_ticks(16'h7FFF, 16'h8000);
        drain();
        write_reg(ADDR_MPT, 32'hFFFF_FFFF);
        write_reg(ADDR_TPT, 32'hFFFF_FFFF);
        foreach (edge_vals[i])
            foreach (edge_vals[j])
                send_ticks(edge_vals[i], edge_vals[j]);
        drain();
        write_reg(ADDR_MPT, 32'h0001_0000);
        write_reg(ADDR_TPT, 32'h0400_0000);
        repeat (4) send_ticks(16'h7FFF, 16'h8000);

        // Random phases with shifting idling
        send_idle = 13; recv_idle = 65;
        random_phase(500, $urandom, $urandom);
        send_idle = 65; recv_idle = 13;
        random_phase(500, $urandom_range(32'h0010_0000), $urandom);
        send_idle = 0; recv_idle = 0;
        random_phase(275, 32'hFFFF_FFFF, 32'h0000_0000);
        random_phase(275, $urandom, 32'hFFFF_FFFF);

        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
